[sv/matrix_multiply_core_macros.svh]
// ----------------------------------------------------------------------------
// Matrix multiply core assertion macros
// Clocked property shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_CORE_MACROS_SVH

// same-cycle implication
`define MMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/mmc_pkg.sv]
// ----------------------------------------------------------------------------
// Matrix multiply core package
// Command codes, register indexes, field widths and the pipeline tag type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mmc_pkg;

   localparam int CMD_W  = 2;
   localparam int IDX_W  = 3;
   localparam int DIM_W  = 4;
   localparam int CSR_AW = 2;
   localparam int IN_W   = 16;
   localparam int OUT_W  = 32;

   localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   localparam logic [CSR_AW-1:0] REG_ROWS_A    = 2'd0;
   localparam logic [CSR_AW-1:0] REG_INNER_DIM = 2'd1;
   localparam logic [CSR_AW-1:0] REG_COLS_B    = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   typedef struct packed {
      logic             first;
      logic             last_t;
      logic             last_el;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } mmc_tag_type;

endpackage

`default_nettype wire

[sv/mmc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[sv/matrix_multiply_core.sv]
// ----------------------------------------------------------------------------
// Matrix multiply core
// Loads A and B element by element, then streams the product A x B.
// ----------------------------------------------------------------------------
// A load beat leaves busy low, so loads may come back to back. A compute
// beat raises busy and emits rows_a x cols_b results in row-major order,
// each the sum of inner_dim products. The pace is set by the single
// multiply-accumulate unit, fed by one read of each operand memory per cycle.
// Results are shown for one cycle on the rsp_ ports with rsp_valid and cannot
// be held off; busy drops together with the last result. Sizes of 0 act as 1,
// sizes above MAX_DIM act as MAX_DIM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_core import mmc_pkg::*; #(
   parameter int MAX_DIM   = 8,
   parameter int ELEM_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [CMD_W-1:0]        req_command,
   input  wire logic [IDX_W-1:0]        req_row_index,
   input  wire logic [IDX_W-1:0]        req_col_index,
   input  wire logic signed [IN_W-1:0]  req_element,
   output logic                         rsp_valid,
   output logic [IDX_W-1:0]             rsp_out_row,
   output logic [IDX_W-1:0]             rsp_out_col,
   output logic signed [OUT_W-1:0]      rsp_product_value,
   output logic                         rsp_last,
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_AW-1:0]       csr_addr,
   input  wire logic [DIM_W-1:0]        csr_wdata
);

   localparam int DEPTH    = MAX_DIM * MAX_DIM;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(MAX_DIM);
   localparam int PROD_W   = 2 * ELEM_BITS;
   localparam int ACC_RAW  = PROD_W + $clog2(MAX_DIM);
   localparam int ACC_W    = (ACC_RAW > OUT_W + 1) ? ACC_RAW : OUT_W + 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ISSUE = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;

   localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

   logic [DIM_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [DIM_W-1:0] dim_m, dim_k, dim_n;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, t_ff, t_in;
   logic             t_last, j_last, i_last, issue;

   logic             accept, load_a, load_b;
   logic [ADDR_W-1:0] ld_addr, a_raddr, b_raddr;
   logic [ELEM_BITS-1:0] ld_data, a_rdata, b_rdata;

   logic              s1_valid_ff, s2_valid_ff;
   mmc_tag_type       s0_tag, s1_tag_ff, s2_tag_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic                    rsp_valid_ff;
   logic [IDX_W-1:0]        rsp_row_ff, rsp_col_ff;
   logic signed [OUT_W-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff;

   // effective sizes
   always_comb begin
      dim_m = (rows_a_ff == '0) ? DIM_W'(1) :
              (rows_a_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_a_ff;
      dim_k = (inner_dim_ff == '0) ? DIM_W'(1) :
              (inner_dim_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : inner_dim_ff;
      dim_n = (cols_b_ff == '0) ? DIM_W'(1) :
              (cols_b_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            REG_ROWS_A:    rows_a_ff    <= csr_wdata;
            REG_INNER_DIM: inner_dim_ff <= csr_wdata;
            REG_COLS_B:    cols_b_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // load path
   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign load_a = accept && (req_command == CMD_LOAD_A) &&
                   (DIM_W'(req_row_index) < dim_m) && (DIM_W'(req_col_index) < dim_k);
   assign load_b = accept && (req_command == CMD_LOAD_B) &&
                   (DIM_W'(req_row_index) < dim_k) && (DIM_W'(req_col_index) < dim_n);
   assign ld_addr = ADDR_W'(req_row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(req_col_index);
   assign ld_data = ELEM_BITS'(req_element);

   // index sequencer
   assign t_last = (DIM_W'(t_ff) + DIM_W'(1)) == dim_k;
   assign j_last = (DIM_W'(j_ff) + DIM_W'(1)) == dim_n;
   assign i_last = (DIM_W'(i_ff) + DIM_W'(1)) == dim_m;
   assign issue  = (state_ff == S_ISSUE);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      t_in     = t_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_command == CMD_COMPUTE)) begin
               state_in = S_ISSUE;
               i_in     = '0;
               j_in     = '0;
               t_in     = '0;
            end
         end
         S_ISSUE: begin
            if (t_last) begin
               t_in = '0;
               if (j_last) begin
                  j_in = '0;
                  if (i_last) begin
                     state_in = S_DRAIN;
                  end else begin
                     i_in = i_ff + CNT_W'(1);
                  end
               end else begin
                  j_in = j_ff + CNT_W'(1);
               end
            end else begin
               t_in = t_ff + CNT_W'(1);
            end
         end
         S_DRAIN: begin
            if (s2_valid_ff && s2_tag_ff.last_el) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      t_ff <= t_in;
   end

   assign a_raddr = ADDR_W'(i_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(t_ff);
   assign b_raddr = ADDR_W'(t_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(j_ff);

   always_comb begin
      s0_tag.first   = (t_ff == '0);
      s0_tag.last_t  = t_last;
      s0_tag.last_el = t_last && j_last && i_last;
      s0_tag.row     = IDX_W'(i_ff);
      s0_tag.col     = IDX_W'(j_ff);
   end

   mmc_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (DEPTH)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (load_a),
      .wr_addr (ld_addr),
      .wr_data (ld_data),
      .rd_en   (issue),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   mmc_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (DEPTH)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (load_b),
      .wr_addr (ld_addr),
      .wr_data (ld_data),
      .rd_en   (issue),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   // multiply-accumulate pipeline
   always_comb begin
      acc_in = (s2_tag_ff.first ? '0 : acc_ff) + ACC_W'(prod_ff);
      if (acc_in > SAT_MAX) begin
         rsp_value_in = SAT_MAX[OUT_W-1:0];
      end else if (acc_in < SAT_MIN) begin
         rsp_value_in = SAT_MIN[OUT_W-1:0];
      end else begin
         rsp_value_in = acc_in[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff && s2_tag_ff.last_t;
      end
      s1_tag_ff <= s0_tag;
      s2_tag_ff <= s1_tag_ff;
      prod_ff   <= $signed(a_rdata) * $signed(b_rdata);
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (s2_valid_ff && s2_tag_ff.last_t) begin
         rsp_row_ff   <= s2_tag_ff.row;
         rsp_col_ff   <= s2_tag_ff.col;
         rsp_value_ff <= rsp_value_in;
         rsp_last_ff  <= s2_tag_ff.last_el;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

[sv/mmc_checker.sv]
// ----------------------------------------------------------------------------
// Matrix multiply core checker
// Port-level properties of the command and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "matrix_multiply_core_macros.svh"

module mmc_checker import mmc_pkg::*; (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    start,
   input wire logic                    busy,
   input wire logic [CMD_W-1:0]        req_command,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_last
);

   `MMC_ASSERT_NEXT(a_compute_sets_busy, clock, reset, start && !busy && req_command == CMD_COMPUTE, busy, "compute beat did not raise busy")
   `MMC_ASSERT_NEXT(a_load_keeps_idle, clock, reset, start && !busy && (req_command == CMD_LOAD_A || req_command == CMD_LOAD_B), !busy, "load beat raised busy")
   `MMC_ASSERT_NOW(a_rsp_follows_busy, clock, reset, rsp_valid, $past(busy), "result beat without a running compute")
   `MMC_ASSERT_NOW(a_last_ends_busy, clock, reset, rsp_valid && rsp_last, !busy, "busy still high on last result")
   `MMC_ASSERT_NOW(a_inner_rsp_busy, clock, reset, rsp_valid && !rsp_last, busy, "non-final result while idle")

endmodule

bind matrix_multiply_core mmc_checker u_mmc_checker (.*);

`default_nettype wire
